>>> rtl/dacc_pkg.sv
// ---------------------------------------------------------------------------
// dacc_pkg
// Shared widths, codes, controller/datapath bundles and helpers for the
// decimal accumulator machine.
// ---------------------------------------------------------------------------
`default_nettype none

package dacc_pkg;

    // Sizes
    localparam int MEM_WORDS_DEF = 100;
    localparam int WORD_W        = 15;
    localparam int MAG_W         = WORD_W - 1;
    localparam int ACC_W         = 28;
    localparam int PC_W          = 7;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int OPC_W         = 7;
    localparam int EXEC_W        = 4;

    // Decimal word limits and the split of a word by 100
    localparam logic signed [WORD_W-1:0] WORD_LIMIT = 15'sd9999;
    localparam logic signed [ACC_W-1:0]  ACC_LIMIT  = 28'sd9999;
    localparam logic [MAG_W-1:0]         DEC_BASE   = 14'd100;
    localparam logic [12:0]              DIV100_MUL = 13'd5243;
    localparam int                       DIV100_SHIFT = 19;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXEC    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PC_RANGE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE_STOP = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd6;

    // Instruction opcodes
    localparam logic [OPC_W-1:0] OP_NOP      = 7'd0;
    localparam logic [OPC_W-1:0] OP_READ     = 7'd10;
    localparam logic [OPC_W-1:0] OP_WRITE    = 7'd11;
    localparam logic [OPC_W-1:0] OP_LOAD     = 7'd20;
    localparam logic [OPC_W-1:0] OP_STORE    = 7'd21;
    localparam logic [OPC_W-1:0] OP_ADD      = 7'd30;
    localparam logic [OPC_W-1:0] OP_SUB      = 7'd31;
    localparam logic [OPC_W-1:0] OP_DIV      = 7'd32;
    localparam logic [OPC_W-1:0] OP_MUL      = 7'd33;
    localparam logic [OPC_W-1:0] OP_BRANCH   = 7'd40;
    localparam logic [OPC_W-1:0] OP_BRNEG    = 7'd41;
    localparam logic [OPC_W-1:0] OP_BRZERO   = 7'd42;
    localparam logic [OPC_W-1:0] OP_HALT     = 7'd43;

    // Datapath execute actions
    localparam logic [EXEC_W-1:0] EX_NONE  = 4'd0;
    localparam logic [EXEC_W-1:0] EX_READ  = 4'd1;
    localparam logic [EXEC_W-1:0] EX_WRITE = 4'd2;
    localparam logic [EXEC_W-1:0] EX_LOAD  = 4'd3;
    localparam logic [EXEC_W-1:0] EX_STORE = 4'd4;
    localparam logic [EXEC_W-1:0] EX_ADD   = 4'd5;
    localparam logic [EXEC_W-1:0] EX_SUB   = 4'd6;
    localparam logic [EXEC_W-1:0] EX_MUL   = 4'd7;
    localparam logic [EXEC_W-1:0] EX_JUMP  = 4'd8;
    localparam logic [EXEC_W-1:0] EX_HALT  = 4'd9;
    localparam logic [EXEC_W-1:0] EX_DIVZ  = 4'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              mem_load;
        logic              restart;
        logic              idle_stop;
        logic              pc_stop;
        logic              fetch;
        logic              decode;
        logic              split;
        logic [EXEC_W-1:0] exec;
        logic              div_start;
        logic              div_finish;
        logic              check;
        logic              emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              stopped;
        logic              pc_oor;
        logic [OPC_W-1:0]  op;
        logic              m_zero;
        logic              acc_neg;
        logic              acc_zero;
        logic              div_done;
        logic              out_free;
    } stat_t;

    // Clamp a value to the decimal word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > ACC_LIMIT) begin
            r = WORD_LIMIT;
        end else if (x < -ACC_LIMIT) begin
            r = -WORD_LIMIT;
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dacc_div.sv
// ---------------------------------------------------------------------------
// dacc_div
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. Operands are decimal words; the divisor is never zero when started.
// ---------------------------------------------------------------------------
`default_nettype none

module dacc_div
    import dacc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [WORD_W-1:0] dividend,
    input  wire logic signed [WORD_W-1:0] divisor,
    output logic                          done,
    output logic signed [WORD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W:0]   rem_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] den_reg;
    logic             neg_reg;

    logic signed [WORD_W-1:0] a_abs;
    logic signed [WORD_W-1:0] b_abs;
    logic [MAG_W:0]           rem_sh;
    logic                     ge;

    // Magnitudes and one restoring step
    always_comb begin
        a_abs  = dividend[WORD_W-1] ? -dividend : dividend;
        b_abs  = divisor[WORD_W-1] ? -divisor : divisor;
        rem_sh = {rem_reg[MAG_W-1:0], quo_reg[MAG_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift remainder and quotient
    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= a_abs[MAG_W-1:0];
            den_reg <= b_abs[MAG_W-1:0];
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end else if (busy_reg) begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[MAG_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

`default_nettype wire

>>> rtl/dacc_ctrl.sv
// ---------------------------------------------------------------------------
// dacc_ctrl
// Controller state machine: accepts an item, walks the datapath through
// load, restart or fetch/decode/execute, and hands the result out.
// ---------------------------------------------------------------------------
`default_nettype none

module dacc_ctrl
    import dacc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FETCH    = 3'd2;
    localparam logic [2:0] S_SPLIT    = 3'd3;
    localparam logic [2:0] S_OPER     = 3'd4;
    localparam logic [2:0] S_DIV      = 3'd5;
    localparam logic [2:0] S_CHECK    = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (stat.kind)
                    KIND_LOAD: begin
                        cmd.mem_load = 1'b1;
                        state_next   = S_DONE;
                    end
                    KIND_EXEC: begin
                        if (stat.stopped) begin
                            cmd.idle_stop = 1'b1;
                            state_next    = S_DONE;
                        end else if (stat.pc_oor) begin
                            cmd.pc_stop = 1'b1;
                            state_next  = S_DONE;
                        end else begin
                            cmd.fetch  = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    default: begin
                        // restart, and the unused kind code
                        cmd.restart = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_FETCH: begin
                cmd.decode = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = S_OPER;
            end
            S_OPER: begin
                state_next = S_CHECK;
                unique case (stat.op)
                    OP_READ:   cmd.exec = EX_READ;
                    OP_WRITE:  cmd.exec = EX_WRITE;
                    OP_LOAD:   cmd.exec = EX_LOAD;
                    OP_STORE:  cmd.exec = EX_STORE;
                    OP_ADD:    cmd.exec = EX_ADD;
                    OP_SUB:    cmd.exec = EX_SUB;
                    OP_MUL:    cmd.exec = EX_MUL;
                    OP_DIV: begin
                        if (stat.m_zero) begin
                            cmd.exec = EX_DIVZ;
                        end else begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    OP_BRANCH: cmd.exec = EX_JUMP;
                    OP_BRNEG:  cmd.exec = stat.acc_neg ? EX_JUMP : EX_NONE;
                    OP_BRZERO: cmd.exec = stat.acc_zero ? EX_JUMP : EX_NONE;
                    OP_HALT:   cmd.exec = EX_HALT;
                    default:   cmd.exec = EX_NONE;
                endcase
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.div_finish = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dacc_dp.sv
// ---------------------------------------------------------------------------
// dacc_dp
// Datapath: program memory with per-word valid bits, accumulator, program
// counter, instruction split, arithmetic, divider and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dacc_dp
    import dacc_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    input  wire logic [KIND_W-1:0]        item_kind,
    input  wire logic [PC_W-1:0]          item_addr,
    input  wire logic signed [WORD_W-1:0] item_value,
    input  wire logic signed [WORD_W-1:0] item_read,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [STATUS_W-1:0]           res_status,
    output logic                          res_out_valid,
    output logic signed [WORD_W-1:0]      res_out_word,
    output logic signed [ACC_W-1:0]       res_acc,
    output logic [PC_W-1:0]               res_pc,
    output logic                          res_stopped
);

    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int PROD_W = MAG_W + 13;

    // Captured item
    logic [KIND_W-1:0]        kind_reg;
    logic [PC_W-1:0]          addr_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic signed [WORD_W-1:0] rd_reg;

    // Architectural state
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic                     stop_reg, stop_next;

    // Per-item result fields
    logic [STATUS_W-1:0]      st_reg, st_next;
    logic                     wr_reg, wr_next;
    logic signed [WORD_W-1:0] ow_reg, ow_next;

    // Program memory
    logic signed [WORD_W-1:0] mem [MEM_WORDS];
    logic [MEM_WORDS-1:0]     mvalid_reg;
    logic signed [WORD_W-1:0] rdata_reg;
    logic                     rvalid_reg;
    logic                     mem_we;
    logic [PC_W-1:0]          mem_waddr;
    logic signed [WORD_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [PC_W-1:0]          mem_raddr;
    logic signed [WORD_W-1:0] mword;

    // Instruction split
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [OPC_W-1:0]         q_reg;
    logic [OPC_W-1:0]         op_reg;
    logic [PC_W-1:0]          opd_reg;
    logic [PROD_W-1:0]        prod;
    logic [PC_W-1:0]          opd_calc;

    // Arithmetic
    logic signed [2*WORD_W-1:0] mul_full;
    logic signed [WORD_W-1:0]   div_q;
    logic                       div_done;

    // Result register
    logic                     res_valid_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic                     res_wr_reg;
    logic signed [WORD_W-1:0] res_ow_reg;
    logic signed [ACC_W-1:0]  res_acc_reg;
    logic [PC_W-1:0]          res_pc_reg;
    logic                     res_stop_reg;

    // Unwritten words read as zero
    assign mword = rvalid_reg ? rdata_reg : '0;

    // Divide the fetched word by 100 through a reciprocal multiply
    assign prod     = mword[MAG_W-1:0] * DIV100_MUL;
    assign opd_calc = PC_W'(mag_reg - MAG_W'(q_reg) * DEC_BASE);
    assign mul_full = $signed(acc_reg[WORD_W-1:0]) * mword;

    // Memory read port select
    assign mem_re    = cmd.fetch || cmd.split;
    assign mem_raddr = cmd.split ? opd_calc : pc_reg;

    // Next-state logic for accumulator, pc, flags and memory writes
    always_comb begin
        acc_next  = acc_reg;
        pc_next   = pc_reg;
        stop_next = stop_reg;
        st_next   = st_reg;
        wr_next   = wr_reg;
        ow_next   = ow_reg;
        mem_we    = 1'b0;
        mem_waddr = opd_reg;
        mem_wdata = sat_word(ACC_W'(rd_reg));

        if (cmd.capture) begin
            st_next = ST_OK;
            wr_next = 1'b0;
            ow_next = '0;
        end
        if (cmd.mem_load) begin
            st_next   = ST_LOADED;
            mem_we    = addr_reg < PC_W'(MEM_WORDS);
            mem_waddr = addr_reg;
            mem_wdata = sat_word(ACC_W'(value_reg));
        end
        if (cmd.restart) begin
            acc_next  = '0;
            pc_next   = '0;
            stop_next = 1'b0;
            st_next   = ST_OK;
        end
        if (cmd.idle_stop) begin
            st_next = ST_IDLE_STOP;
        end
        if (cmd.pc_stop) begin
            stop_next = 1'b1;
            st_next   = ST_PC_RANGE;
        end
        if (cmd.split) begin
            pc_next = pc_reg + PC_W'(1);
        end

        case (cmd.exec)
            EX_READ: begin
                mem_we    = 1'b1;
                mem_wdata = sat_word(ACC_W'(rd_reg));
            end
            EX_WRITE: begin
                wr_next = 1'b1;
                ow_next = mword;
            end
            EX_LOAD:  acc_next = ACC_W'(mword);
            EX_STORE: begin
                mem_we    = 1'b1;
                mem_wdata = sat_word(acc_reg);
            end
            EX_ADD:   acc_next = acc_reg + ACC_W'(mword);
            EX_SUB:   acc_next = acc_reg - ACC_W'(mword);
            EX_MUL:   acc_next = ACC_W'(mul_full);
            EX_JUMP:  pc_next = opd_reg;
            EX_HALT: begin
                stop_next = 1'b1;
                st_next   = ST_HALTED;
            end
            EX_DIVZ:  st_next = ST_DIV_ZERO;
            default: ;
        endcase

        if (cmd.div_finish) begin
            acc_next = ACC_W'(div_q);
        end
        // Stop on an accumulator outside the decimal range
        if (cmd.check && (acc_reg > ACC_LIMIT || acc_reg < -ACC_LIMIT)) begin
            stop_next = 1'b1;
            st_next   = ST_OVERFLOW;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            acc_reg       <= '0;
            pc_reg        <= '0;
            stop_reg      <= 1'b0;
            mvalid_reg    <= '0;
            rvalid_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            pc_reg   <= pc_next;
            stop_reg <= stop_next;
            if (mem_we) begin
                mvalid_reg[mem_waddr[ADDR_W-1:0]] <= 1'b1;
            end
            if (mem_re) begin
                rvalid_reg <= mvalid_reg[mem_raddr[ADDR_W-1:0]];
            end
            if (cmd.emit) begin
                res_valid_reg <= 1'b1;
            end else if (result_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Memory array, registered read
    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr[ADDR_W-1:0]];
        end
    end

    // Item capture, instruction split and result payload
    always_ff @(posedge clk) begin
        st_reg <= st_next;
        wr_reg <= wr_next;
        ow_reg <= ow_next;
        if (cmd.capture) begin
            kind_reg  <= item_kind;
            addr_reg  <= item_addr;
            value_reg <= item_value;
            rd_reg    <= item_read;
        end
        if (cmd.decode) begin
            mag_reg <= mword[MAG_W-1:0];
            neg_reg <= mword[WORD_W-1];
            q_reg   <= prod[DIV100_SHIFT +: OPC_W];
        end
        if (cmd.split) begin
            // negative words never decode to an instruction
            op_reg  <= neg_reg ? OP_NOP : q_reg;
            opd_reg <= opd_calc;
        end
        if (cmd.emit) begin
            res_status_reg <= st_reg;
            res_wr_reg     <= wr_reg;
            res_ow_reg     <= ow_reg;
            res_acc_reg    <= acc_reg;
            res_pc_reg     <= pc_reg;
            res_stop_reg   <= stop_reg;
        end
    end

    dacc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg[WORD_W-1:0]),
        .divisor  (mword),
        .done     (div_done),
        .quotient (div_q)
    );

    // Status to the controller
    always_comb begin
        stat.kind     = kind_reg;
        stat.stopped  = stop_reg;
        stat.pc_oor   = pc_reg >= PC_W'(MEM_WORDS);
        stat.op       = op_reg;
        stat.m_zero   = mword == '0;
        stat.acc_neg  = acc_reg < 0;
        stat.acc_zero = acc_reg == '0;
        stat.div_done = div_done;
        stat.out_free = !res_valid_reg || result_ready;
    end

    assign result_valid  = res_valid_reg;
    assign res_status    = res_status_reg;
    assign res_out_valid = res_wr_reg;
    assign res_out_word  = res_ow_reg;
    assign res_acc       = res_acc_reg;
    assign res_pc        = res_pc_reg;
    assign res_stopped   = res_stop_reg;

endmodule

`default_nettype wire

>>> rtl/decimal_accumulator_cpu_unit.sv
// ---------------------------------------------------------------------------
// decimal_accumulator_cpu_unit
// Top level of the decimal accumulator machine: controller plus datapath.
// ---------------------------------------------------------------------------
// One item is in work at a time; item_ready is high only while the block
// waits for a new item, and a finished result waits in an output register.
// A load or restart item goes from dispatch straight to the result state.
// An executed instruction passes through dispatch with the read of the word
// at the program counter, opcode split by a reciprocal multiply, operand
// split and operand read, execute, range check and result. DIVIDE runs the
// bit-serial divider, one quotient bit per cycle over 14 bits, between
// execute and range check. A result that is not taken holds the next
// finished item until the output register frees. Program memory clears
// at reset through one valid bit per word, with no clearing pass; the block
// takes items right after reset.
`default_nettype none

module decimal_accumulator_cpu_unit
    import dacc_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire logic [KIND_W-1:0]        opcode,
    input  wire logic [PC_W-1:0]          address,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire logic signed [WORD_W-1:0] read_value,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [STATUS_W-1:0]           status,
    output logic                          out_valid,
    output logic signed [WORD_W-1:0]      out_word,
    output logic signed [ACC_W-1:0]       acc_now,
    output logic [PC_W-1:0]               pc_now,
    output logic                          is_stopped
);

    cmd_t  cmd;
    stat_t stat;

    dacc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    dacc_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_kind     (opcode),
        .item_addr     (address),
        .item_value    (value),
        .item_read     (read_value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .res_status    (status),
        .res_out_valid (out_valid),
        .res_out_word  (out_word),
        .res_acc       (acc_now),
        .res_pc        (pc_now),
        .res_stopped   (is_stopped)
    );

    // One item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in work");

    // Stopping results must show the machine stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_HALTED || status == ST_OVERFLOW ||
                         status == ST_PC_RANGE) |-> is_stopped)
        else $error("stop status without stop flag");

    // A word is only emitted by a normally completed WRITE
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_valid |-> status == ST_OK)
        else $error("emitted word with non-ok status");

    // Without an emitted word the output word reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> out_word == '0)
        else $error("out_word nonzero without WRITE");

    // Never overwrite a result still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !result_valid || result_ready)
        else $error("result register overwritten");

endmodule

`default_nettype wire
